// ===== rtl/core/acuc_pkg.sv =====
package acuc_pkg;

    localparam int CHANNEL_COUNT = 16;

    typedef struct packed {
        logic [3:0]  channel;
        logic [11:0] raw_code;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         channel_echo;
        logic signed [31:0] converted_value;
        logic               saturated;
    } t_out_item;

    // formula classes
    localparam logic [2:0] CLS_VOLT = 3'd0;
    localparam logic [2:0] CLS_CUR  = 3'd1;
    localparam logic [2:0] CLS_TEMP = 3'd2;
    localparam logic [2:0] CLS_RAW  = 3'd3;
    localparam logic [2:0] CLS_DIV  = 3'd4;
    localparam logic [2:0] CLS_NONE = 3'd5;

    // pipeline depths
    localparam int LIN_LAT  = 3;
    localparam int DGEN_LAT = 4;
    localparam int SQRT_LAT = 32;
    localparam int TFIN_LAT = 4;
    localparam int TEMP_LAT = DGEN_LAT + SQRT_LAT + TFIN_LAT;

    // linear lanes: value = code*a + floor((code*b + h)/d) + offset
    localparam int LIN_A_W  = 17;
    localparam int LIN_B_W  = 17;
    localparam int LIN_H_W  = 17;
    localparam int LIN_D_W  = 18;
    localparam int LIN_Y_W  = 29;
    localparam int LIN_Q_W  = 13;
    localparam int LIN_SHIFT = 40;

    localparam int VOLT_K = 32768;
    localparam int VOLT_D = 819;
    localparam int CUR_K  = 4096000;
    localparam int CUR_D  = 27027;
    localparam int DIV_K  = 22183936;
    localparam int DIV_D  = 254163;

    localparam logic [LIN_A_W-1:0] VOLT_A = LIN_A_W'(VOLT_K / VOLT_D);
    localparam logic [LIN_B_W-1:0] VOLT_B = LIN_B_W'(VOLT_K % VOLT_D);
    localparam logic [LIN_H_W-1:0] VOLT_H = LIN_H_W'(VOLT_D / 2);
    localparam logic [31:0] VOLT_M = 32'((64'd1 << LIN_SHIFT) / 64'(VOLT_D));

    localparam logic [LIN_A_W-1:0] CUR_A = LIN_A_W'(CUR_K / CUR_D);
    localparam logic [LIN_B_W-1:0] CUR_B = LIN_B_W'(CUR_K % CUR_D);
    localparam logic [LIN_H_W-1:0] CUR_H = LIN_H_W'(CUR_D / 2);
    localparam logic [31:0] CUR_M = 32'((64'd1 << LIN_SHIFT) / 64'(CUR_D));
    localparam logic signed [30:0] CUR_OFF = -31'sd409600;

    localparam logic [LIN_A_W-1:0] DIV_A = LIN_A_W'(DIV_K / DIV_D);
    localparam logic [LIN_B_W-1:0] DIV_B = LIN_B_W'(DIV_K % DIV_D);
    localparam logic [LIN_H_W-1:0] DIV_H = LIN_H_W'(DIV_D / 2);
    localparam logic [31:0] DIV_M = 32'((64'd1 << LIN_SHIFT) / 64'(DIV_D));

    localparam logic [LIN_A_W-1:0] RAW_A = LIN_A_W'(65536);

    // temperature root argument, unsigned Q6.48 = floor(num * 2^48 / den)
    localparam logic [31:0]  TD_DEN    = 32'd4095000000;
    localparam logic [127:0] TD_A_FULL = 128'd149242520700 << 48;
    localparam logic [127:0] TD_B_FULL = 128'd17600000 << 48;
    localparam logic [127:0] TD_QA_FULL = TD_A_FULL / 128'(TD_DEN);
    localparam logic [127:0] TD_RA_FULL = TD_A_FULL % 128'(TD_DEN);
    localparam logic [127:0] TD_QB_FULL = TD_B_FULL / 128'(TD_DEN);
    localparam logic [127:0] TD_RB_FULL = TD_B_FULL % 128'(TD_DEN);
    localparam logic [127:0] TD_C0_FULL = 128'(TD_DEN) - 128'd1 - TD_RA_FULL;
    localparam logic [127:0] TD_M_FULL  = (128'd1 << 56) / 128'(TD_DEN);
    localparam logic [53:0] TD_QA = TD_QA_FULL[53:0];
    localparam logic [40:0] TD_QB = TD_QB_FULL[40:0];
    localparam logic [31:0] TD_RB = TD_RB_FULL[31:0];
    localparam logic [31:0] TD_C0 = TD_C0_FULL[31:0];
    localparam logic [24:0] TD_M  = TD_M_FULL[24:0];

    // temperature finish: round((1000*s - 5506*2^24)*25/22528) + 30*2^16
    localparam logic [14:0] TF_MUL   = 15'd25000;
    localparam logic [41:0] TF_OFF25 = 42'd2309383782400;
    localparam logic [13:0] TF_HALF  = 14'd11264;
    localparam logic [3:0]  TF_DIV   = 4'd11;
    localparam logic [31:0] TF_M11   = 32'((64'd1 << 35) / 64'd11);
    localparam logic signed [31:0] TF_BASE = 32'sd1966080;

    function automatic logic [2:0] chan_class(input logic [3:0] ch);
        logic [2:0] c;
        if ({1'b0, ch} >= 5'(CHANNEL_COUNT)) begin
            c = CLS_NONE;
        end else if (ch < 4'd8) begin
            c = CLS_VOLT;
        end else if (ch == 4'd8 || ch == 4'd9) begin
            c = CLS_CUR;
        end else if (ch == 4'd10) begin
            c = CLS_TEMP;
        end else if (ch == 4'd11) begin
            c = CLS_RAW;
        end else begin
            c = CLS_DIV;
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/adc_channel_unit_conversion_top.sv =====
// channel   direction   handshake                     payload
// in        input       i_in_valid / o_in_stall       i_in  (channel, raw_code)
// out       output      o_out_valid / i_out_stall     o_out (channel_echo, converted_value,
//                                                            saturated)
//
// one item per cycle sustained while the sink does not stall; each item passes through the
// temperature lane (4 argument stages, 32 square root stages, 4 finish stages) and then
// the output register on its way from accept to o_out_valid
// synchronous active-low reset clears the valid bits and the output register valid
// the whole pipeline advances together; it holds only while a result sits in the
// output register and the sink stalls, so o_in_stall follows that condition
module adc_channel_unit_conversion_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  acuc_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output acuc_pkg::t_out_item o_out
);

    localparam int LAST    = acuc_pkg::TEMP_LAT - 1;
    localparam int DLY_LEN = acuc_pkg::TEMP_LAT - acuc_pkg::LIN_LAT;

    localparam logic signed [33:0] W_MAX = 34'sd2147483647;
    localparam logic signed [33:0] W_MIN = -34'sd2147483648;

    // pipeline advance
    logic en;

    // valid bits and channel travel beside the datapath
    logic [acuc_pkg::TEMP_LAT-1:0] r_vld;
    logic [3:0]                    r_ch [acuc_pkg::TEMP_LAT];

    // linear lane result, delayed to line up with the temperature lane
    logic signed [31:0] lin_v;
    logic signed [31:0] r_lin [DLY_LEN];

    // temperature lane
    logic [53:0]        root_arg;
    logic [31:0]        root;
    logic signed [31:0] temp_v;

    logic signed [33:0]  wide;
    acuc_pkg::t_out_item n_out, r_out;
    logic                r_out_valid;

    assign en         = !r_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    acuc_lin u_lin (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_channel (i_in.channel),
        .i_code    (i_in.raw_code),
        .o_value   (lin_v)
    );

    acuc_dgen u_dgen (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_code (i_in.raw_code),
        .o_arg  (root_arg)
    );

    acuc_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_arg  (root_arg),
        .o_root (root)
    );

    acuc_tfin u_tfin (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_root  (root),
        .o_value (temp_v)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[acuc_pkg::TEMP_LAT-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ch[0] <= i_in.channel;
            for (int k = 1; k < acuc_pkg::TEMP_LAT; k++) begin
                r_ch[k] <= r_ch[k-1];
            end
            r_lin[0] <= lin_v;
            for (int k = 1; k < DLY_LEN; k++) begin
                r_lin[k] <= r_lin[k-1];
            end
        end
    end

    // pick the lane for this channel, then clip to the q16.16 range
    always_comb begin
        case (acuc_pkg::chan_class(r_ch[LAST]))
            acuc_pkg::CLS_TEMP: wide = {{2{temp_v[31]}}, temp_v};
            acuc_pkg::CLS_NONE: wide = '0;
            default:            wide = {{2{r_lin[DLY_LEN-1][31]}}, r_lin[DLY_LEN-1]};
        endcase
        n_out.channel_echo = r_ch[LAST];
        if (wide > W_MAX) begin
            n_out.converted_value = 32'sh7FFFFFFF;
            n_out.saturated       = 1'b1;
        end else if (wide < W_MIN) begin
            n_out.converted_value = 32'sh80000000;
            n_out.saturated       = 1'b1;
        end else begin
            n_out.converted_value = wide[31:0];
            n_out.saturated       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_vld[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // a clipped result holds one of the two range limits
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.saturated |->
            (o_out.converted_value == 32'sh7FFFFFFF ||
             o_out.converted_value == 32'sh80000000))
        else $error("saturated result not at a range limit");

    // channels beyond the populated count read as zero
    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ({1'b0, o_out.channel_echo} >= 5'(acuc_pkg::CHANNEL_COUNT)) |->
            (o_out.converted_value == 32'sd0 && !o_out.saturated))
        else $error("absent channel gave a nonzero result");

    // a new result only comes from the end of the valid line
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_vld[LAST]))
        else $error("result appeared without an item at the pipeline end");

    // a held pipeline keeps every valid bit in place
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("valid bits moved while the pipeline was held");

endmodule

// ===== rtl/core/acuc_lin.sv =====
module acuc_lin (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [3:0]         i_channel,
    input  logic [11:0]        i_code,
    output logic signed [31:0] o_value
);

    logic [acuc_pkg::LIN_A_W-1:0] a;
    logic [acuc_pkg::LIN_B_W-1:0] b;
    logic [acuc_pkg::LIN_H_W-1:0] h;
    logic [acuc_pkg::LIN_D_W-1:0] d;
    logic [31:0]                  m;
    logic signed [30:0]           off;

    logic [acuc_pkg::LIN_Y_W-1:0] n_y, r_y1, r_y2;
    logic [acuc_pkg::LIN_D_W-1:0] r_d1, r_d2;
    logic [31:0]                  r_m1;
    logic signed [30:0]           n_base, r_base1, r_base2;
    logic [60:0]                  prod;
    logic [acuc_pkg::LIN_Q_W-1:0] n_q0, r_q0, q;
    logic [30:0]                  qd, rr;
    logic signed [31:0]           n_v, r_v;

    always_comb begin
        off = '0;
        case (acuc_pkg::chan_class(i_channel))
            acuc_pkg::CLS_VOLT: begin
                a = acuc_pkg::VOLT_A; b = acuc_pkg::VOLT_B; h = acuc_pkg::VOLT_H;
                d = acuc_pkg::LIN_D_W'(acuc_pkg::VOLT_D); m = acuc_pkg::VOLT_M;
            end
            acuc_pkg::CLS_CUR: begin
                a = acuc_pkg::CUR_A; b = acuc_pkg::CUR_B; h = acuc_pkg::CUR_H;
                d = acuc_pkg::LIN_D_W'(acuc_pkg::CUR_D); m = acuc_pkg::CUR_M;
                off = acuc_pkg::CUR_OFF;
            end
            acuc_pkg::CLS_RAW: begin
                // no fraction: y stays zero
                a = acuc_pkg::RAW_A; b = '0; h = '0;
                d = acuc_pkg::LIN_D_W'(acuc_pkg::VOLT_D); m = acuc_pkg::VOLT_M;
            end
            default: begin
                a = acuc_pkg::DIV_A; b = acuc_pkg::DIV_B; h = acuc_pkg::DIV_H;
                d = acuc_pkg::LIN_D_W'(acuc_pkg::DIV_D); m = acuc_pkg::DIV_M;
            end
        endcase
        n_y = acuc_pkg::LIN_Y_W'(29'(i_code) * 29'(b) + 29'(h));
        n_base = $signed(31'(i_code) * 31'(a)) + off;

        // reciprocal estimate, low by at most one
        prod = 61'(r_y1) * 61'(r_m1);
        n_q0 = prod[acuc_pkg::LIN_SHIFT +: acuc_pkg::LIN_Q_W];

        qd = 31'(r_q0) * 31'(r_d2);
        rr = 31'(r_y2) - qd;
        q = r_q0 + acuc_pkg::LIN_Q_W'(rr >= 31'(r_d2));
        n_v = 32'(r_base2) + $signed({19'd0, q});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y1    <= n_y;
            r_d1    <= d;
            r_m1    <= m;
            r_base1 <= n_base;
            r_q0    <= n_q0;
            r_y2    <= r_y1;
            r_d2    <= r_d1;
            r_base2 <= r_base1;
            r_v     <= n_v;
        end
    end

    assign o_value = r_v;

endmodule

// ===== rtl/core/acuc_dgen.sv =====
module acuc_dgen (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [11:0] i_code,
    output logic [53:0] o_arg
);

    logic [44:0] n_p1, r_p1, r_p2;
    logic [52:0] n_qb1, r_qb1, r_qb2, r_qb3;
    logic [57:0] m_prod;
    logic [12:0] n_q0, r_q0, n_q, r_q;
    logic [44:0] qd, rr;
    logic [53:0] n_dq, r_dq;

    always_comb begin
        n_p1  = 45'(i_code) * 45'(acuc_pkg::TD_RB) + 45'(acuc_pkg::TD_C0);
        n_qb1 = 53'(i_code) * 53'(acuc_pkg::TD_QB);

        // quotient estimate, low by at most one
        m_prod = 58'(r_p1[44:12]) * 58'(acuc_pkg::TD_M);
        n_q0   = m_prod[56:44];

        qd  = 45'(r_q0) * 45'(acuc_pkg::TD_DEN);
        rr  = r_p2 - qd;
        n_q = r_q0 + 13'(rr >= 45'(acuc_pkg::TD_DEN));

        n_dq = acuc_pkg::TD_QA - 54'(r_qb3) - 54'(r_q);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1  <= n_p1;
            r_qb1 <= n_qb1;
            r_q0  <= n_q0;
            r_p2  <= r_p1;
            r_qb2 <= r_qb1;
            r_q   <= n_q;
            r_qb3 <= r_qb2;
            r_dq  <= n_dq;
        end
    end

    assign o_arg = r_dq;

endmodule

// ===== rtl/core/acuc_isqrt.sv =====
module acuc_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [53:0] i_arg,
    output logic [31:0] o_root
);

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] res;
    } t_root;

    t_root r_st [acuc_pkg::SQRT_LAT];
    t_root n_st [acuc_pkg::SQRT_LAT];

    function automatic t_root root_step(input t_root s, input int idx);
        t_root       o;
        logic [63:0] bitv;
        logic [63:0] trial;
        bitv  = 64'd1 << (62 - 2 * idx);
        trial = s.res + bitv;
        if (s.rem >= trial) begin
            o.rem = s.rem - trial;
            o.res = (s.res >> 1) + bitv;
        end else begin
            o.rem = s.rem;
            o.res = s.res >> 1;
        end
        return o;
    endfunction

    always_comb begin
        t_root first;
        first.rem = 64'(i_arg);
        first.res = '0;
        n_st[0] = root_step(first, 0);
        for (int g = 1; g < acuc_pkg::SQRT_LAT; g++) begin
            n_st[g] = root_step(r_st[g-1], g);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int g = 0; g < acuc_pkg::SQRT_LAT; g++) begin
                r_st[g] <= n_st[g];
            end
        end
    end

    assign o_root = r_st[acuc_pkg::SQRT_LAT-1].res[31:0];

endmodule

// ===== rtl/core/acuc_tfin.sv =====
module acuc_tfin (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [31:0]        i_root,
    output logic signed [31:0] o_value
);

    logic [41:0]        n_prod, r_prod;
    logic signed [42:0] n_diff;
    logic [41:0]        mag;
    logic [31:0]        n_y, r_y2, r_y3;
    logic               n_neg, r_neg2, r_neg3;
    logic [63:0]        m_prod;
    logic [28:0]        n_q0, r_q0, q;
    logic [31:0]        rr;
    logic signed [31:0] n_v, r_v;

    always_comb begin
        // root is below 2^27 for any code
        n_prod = 42'(i_root[26:0]) * 42'(acuc_pkg::TF_MUL);

        n_diff = $signed({1'b0, r_prod}) - $signed({1'b0, acuc_pkg::TF_OFF25});
        n_neg  = n_diff[42];
        mag    = n_neg ? 42'(-n_diff) : 42'(n_diff);
        n_y    = 32'((43'(mag) + 43'(acuc_pkg::TF_HALF)) >> 11);

        // divide by 11 through the reciprocal, low by at most one
        m_prod = 64'(r_y2) * 64'(acuc_pkg::TF_M11);
        n_q0   = m_prod[63:35];

        rr  = r_y3 - 32'(r_q0) * 32'(acuc_pkg::TF_DIV);
        q   = r_q0 + 29'(rr >= 32'(acuc_pkg::TF_DIV));
        n_v = r_neg3 ? acuc_pkg::TF_BASE - $signed({3'd0, q})
                     : acuc_pkg::TF_BASE + $signed({3'd0, q});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_y2   <= n_y;
            r_neg2 <= n_neg;
            r_q0   <= n_q0;
            r_y3   <= r_y2;
            r_neg3 <= r_neg2;
            r_v    <= n_v;
        end
    end

    assign o_value = r_v;

endmodule
